// ----- src/pcs_pkg.sv -----
// Shared types and constants of the column scanner.
`timescale 1ns / 1ps
`default_nettype none

package pcs_pkg;

    localparam int NOW_W       = 32;
    localparam int COL_W       = 10;
    localparam int BITS_W      = 64;
    localparam int PERIOD_W    = 22;
    localparam int CFG_W       = 32;
    localparam int CFG_AW      = 3;
    localparam int STORE_DEPTH = 1024;
    localparam int DIV_STEPS   = 32;

    localparam int COLUMNS_DEF     = 1024;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [PERIOD_W-1:0] PERIOD_MAX      = 22'd4194303;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET    = 22'd90000;
    localparam logic [CFG_W-1:0]    MIN_SWEEP_RESET = 32'd10000;

    // Register index within the configuration space.
    localparam logic [CFG_AW-3:0] REG_MIN_SWEEP = 1'b0;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_LEFT  = 2'd1,
        REQ_RIGHT = 2'd2,
        REQ_WRITE = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        KIND_DRAWN  = 2'd0,
        KIND_CAL    = 2'd1,
        KIND_BOUNCE = 2'd2,
        KIND_STORED = 2'd3
    } t_kind;

    typedef struct packed {
        t_req               op;
        logic               dir;
        logic [NOW_W-1:0]   now;
        logic [COL_W-1:0]   col;
        logic [BITS_W-1:0]  bits;
    } t_item;

endpackage

`default_nettype wire

// ----- src/pcs_front.sv -----
// Input stage: accepts request words and decodes them into queue items.
`timescale 1ns / 1ps
`default_nettype none

module pcs_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [1:0]                   i_req_type,
    input  wire logic [pcs_pkg::NOW_W-1:0]    i_now_us,
    input  wire logic [pcs_pkg::COL_W-1:0]    i_write_column,
    input  wire logic [pcs_pkg::BITS_W-1:0]   i_column_bits,
    output logic                              o_push,
    output pcs_pkg::t_item                    o_item,
    input  wire logic                         i_full
);

    logic           r_valid;
    logic           n_valid;
    pcs_pkg::t_item r_item;
    pcs_pkg::t_item n_item;
    logic           take;

    assign o_ready = !r_valid || !i_full;
    assign o_push  = r_valid && !i_full;
    assign o_item  = r_item;
    assign take    = i_valid && o_ready;

    always_comb begin
        n_item      = r_item;
        n_valid     = r_valid && !o_push;
        if (take) begin
            n_valid     = 1'b1;
            n_item.op   = pcs_pkg::t_req'(i_req_type);
            n_item.now  = i_now_us;
            n_item.col  = i_write_column;
            n_item.bits = i_column_bits;
            unique case (pcs_pkg::t_req'(i_req_type))
                pcs_pkg::REQ_LEFT: begin
                    n_item.dir = 1'b1;
                end
                pcs_pkg::REQ_TICK, pcs_pkg::REQ_RIGHT, pcs_pkg::REQ_WRITE: begin
                    n_item.dir = 1'b0;
                end
                default: begin
                    n_item.dir = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

endmodule

`default_nettype wire

// ----- src/pcs_queue.sv -----
// Short queue of decoded items between the input stage and the execution unit.
`timescale 1ns / 1ps
`default_nettype none

module pcs_queue #(
    parameter int DEPTH = pcs_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  pcs_pkg::t_item       i_item,
    output logic                 o_full,
    input  wire logic            i_pop,
    output pcs_pkg::t_item       o_item,
    output logic                 o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

    pcs_pkg::t_item r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr;
    logic [AW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

// ----- src/pcs_back.sv -----
// Execution unit: sweep state, shared iterative divider, column store and result register.
`timescale 1ns / 1ps
`default_nettype none

module pcs_back #(
    parameter int COLUMNS = pcs_pkg::COLUMNS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [pcs_pkg::CFG_W-1:0]     i_min_sweep_us,
    input  pcs_pkg::t_item                     i_item,
    input  wire logic                          i_empty,
    output logic                               o_pop,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [1:0]                         o_result_kind,
    output logic [pcs_pkg::COL_W-1:0]          o_column_index,
    output logic [pcs_pkg::BITS_W-1:0]         o_row_bits,
    output logic                               o_direction,
    output logic [pcs_pkg::PERIOD_W-1:0]       o_column_period_us
);

    localparam int PW = $clog2(COLUMNS);
    localparam int NW = pcs_pkg::NOW_W;
    localparam int SW = $clog2(pcs_pkg::DIV_STEPS);
    localparam logic [NW-1:0] LAST_COL   = NW'(COLUMNS - 1);
    localparam logic [NW-1:0] COLUMNS_NW = NW'(COLUMNS);
    localparam logic [NW-1:0] PMAX_NW    = NW'(pcs_pkg::PERIOD_MAX);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_POS  = 4'b0100,
        S_READ = 4'b1000
    } t_state;

    function automatic logic [pcs_pkg::BITS_W-1:0] reverse_bytes(
        input logic [pcs_pkg::BITS_W-1:0] v
    );
        logic [pcs_pkg::BITS_W-1:0] r;
        for (int k = 0; k < 8; k++) begin
            r[8*k +: 8] = v[8*(7-k) +: 8];
        end
        return r;
    endfunction

    // Control and sweep state.
    t_state                      r_state, n_state;
    logic [NW-1:0]               r_sync, n_sync;
    logic [pcs_pkg::PERIOD_W-1:0] r_period, n_period;
    logic                        r_dir, n_dir;
    logic                        r_out_valid, n_out_valid;

    // Working registers.
    pcs_pkg::t_item              r_item, n_item;
    logic [NW-1:0]               r_quo, n_quo;
    logic [NW-1:0]               r_rem, n_rem;
    logic [NW-1:0]               r_div, n_div;
    logic [SW-1:0]               r_cnt, n_cnt;
    logic [pcs_pkg::COL_W-1:0]   r_addr, n_addr;
    logic [pcs_pkg::BITS_W-1:0]  r_rd_data;

    // Result register.
    pcs_pkg::t_kind              r_kind, n_kind;
    logic [pcs_pkg::COL_W-1:0]   r_col, n_col;
    logic [pcs_pkg::BITS_W-1:0]  r_row, n_row;
    logic                        r_out_dir, n_out_dir;
    logic [pcs_pkg::PERIOD_W-1:0] r_out_period, n_out_period;

    logic [pcs_pkg::BITS_W-1:0]  r_mem [pcs_pkg::STORE_DEPTH];

    logic                        out_free;
    logic [NW-1:0]               elapsed;
    logic [NW:0]                 rem_sh;
    logic [NW+1:0]               trial;
    logic                        trial_ge;
    logic [PW-1:0]               pos_clamp;
    logic [PW-1:0]               pos_mirror;
    logic [pcs_pkg::PERIOD_W-1:0] period_sat;
    logic                        mem_we;
    logic                        mem_re;

    assign out_free = !r_out_valid || i_ready;
    assign elapsed  = i_item.now - r_sync;

    // One restoring step per cycle; a zero divisor yields an all-ones quotient.
    assign rem_sh   = {r_rem, r_quo[NW-1]};
    assign trial    = {1'b0, rem_sh} - {2'b00, r_div};
    assign trial_ge = !trial[NW+1];

    assign pos_clamp  = (r_quo > LAST_COL) ? LAST_COL[PW-1:0] : r_quo[PW-1:0];
    assign pos_mirror = r_dir ? pos_clamp : LAST_COL[PW-1:0] - pos_clamp;
    assign period_sat = (r_quo > PMAX_NW) ? pcs_pkg::PERIOD_MAX
                                          : r_quo[pcs_pkg::PERIOD_W-1:0];

    always_comb begin
        n_state      = r_state;
        n_sync       = r_sync;
        n_period     = r_period;
        n_dir        = r_dir;
        n_out_valid  = r_out_valid && !i_ready;
        n_item       = r_item;
        n_quo        = r_quo;
        n_rem        = r_rem;
        n_div        = r_div;
        n_cnt        = r_cnt;
        n_addr       = r_addr;
        n_kind       = r_kind;
        n_col        = r_col;
        n_row        = r_row;
        n_out_dir    = r_out_dir;
        n_out_period = r_out_period;
        o_pop        = 1'b0;
        mem_we       = 1'b0;
        mem_re       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (!i_empty && out_free) begin
                    o_pop  = 1'b1;
                    n_item = i_item;
                    n_quo  = elapsed;
                    n_rem  = '0;
                    n_cnt  = SW'(pcs_pkg::DIV_STEPS - 1);
                    unique case (i_item.op)
                        pcs_pkg::REQ_TICK: begin
                            n_div   = {{(NW - pcs_pkg::PERIOD_W){1'b0}}, r_period};
                            n_state = S_DIV;
                        end
                        pcs_pkg::REQ_LEFT, pcs_pkg::REQ_RIGHT: begin
                            n_dir = i_item.dir;
                            if (elapsed >= i_min_sweep_us) begin
                                n_div   = COLUMNS_NW;
                                n_state = S_DIV;
                            end else begin
                                n_out_valid  = 1'b1;
                                n_kind       = pcs_pkg::KIND_BOUNCE;
                                n_col        = '0;
                                n_row        = '0;
                                n_out_dir    = i_item.dir;
                                n_out_period = r_period;
                            end
                        end
                        pcs_pkg::REQ_WRITE: begin
                            mem_we       = 1'b1;
                            n_out_valid  = 1'b1;
                            n_kind       = pcs_pkg::KIND_STORED;
                            n_col        = i_item.col;
                            n_row        = '0;
                            n_out_dir    = r_dir;
                            n_out_period = r_period;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_DIV: begin
                n_rem = trial_ge ? trial[NW-1:0] : rem_sh[NW-1:0];
                n_quo = {r_quo[NW-2:0], trial_ge};
                if (r_cnt == '0) begin
                    n_state = S_POS;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_POS: begin
                // The result register was emptied when this item left the queue.
                if (r_item.op == pcs_pkg::REQ_TICK) begin
                    n_addr  = pcs_pkg::COL_W'(pos_mirror);
                    mem_re  = 1'b1;
                    n_state = S_READ;
                end else begin
                    n_period     = period_sat;
                    n_sync       = r_item.now;
                    n_out_valid  = 1'b1;
                    n_kind       = pcs_pkg::KIND_CAL;
                    n_col        = '0;
                    n_row        = '0;
                    n_out_dir    = r_dir;
                    n_out_period = period_sat;
                    n_state      = S_IDLE;
                end
            end
            S_READ: begin
                n_out_valid  = 1'b1;
                n_kind       = pcs_pkg::KIND_DRAWN;
                n_col        = r_addr;
                n_row        = reverse_bytes(r_rd_data);
                n_out_dir    = r_dir;
                n_out_period = r_period;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sync      <= '0;
            r_period    <= pcs_pkg::PERIOD_RESET;
            r_dir       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sync      <= n_sync;
            r_period    <= n_period;
            r_dir       <= n_dir;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item       <= n_item;
        r_quo        <= n_quo;
        r_rem        <= n_rem;
        r_div        <= n_div;
        r_cnt        <= n_cnt;
        r_addr       <= n_addr;
        r_kind       <= n_kind;
        r_col        <= n_col;
        r_row        <= n_row;
        r_out_dir    <= n_out_dir;
        r_out_period <= n_out_period;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[i_item.col] <= i_item.bits;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[n_addr];
        end
    end

    assign o_valid            = r_out_valid;
    assign o_result_kind      = r_kind;
    assign o_column_index     = r_col;
    assign o_row_bits         = r_row;
    assign o_direction        = r_out_dir;
    assign o_column_period_us = r_out_period;

    a_pos_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POS) |-> ($past(r_state) == S_DIV && $past(r_cnt) == '0))
        else $error("position step entered without a finished divide");

    a_pop_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (!r_out_valid || i_ready))
        else $error("item dequeued while the result register is still full");

    a_read_is_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_item.op == pcs_pkg::REQ_TICK))
        else $error("store read for an item that is not a column tick");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |->
            ($past(o_pop) || $past(r_state) == S_POS || $past(r_state) == S_READ))
        else $error("result appeared without a finishing step");

endmodule

`default_nettype wire

// ----- src/pov_column_scanner_top.sv -----
// Top level of the column scanner: configuration register and the front, queue and back parts.
`timescale 1ns / 1ps
`default_nettype none

// A request word is taken into a decode register and then a short queue, so the input
// keeps accepting while the execution unit works. Each word gives exactly one result
// word, in order. A column write or a limit event rejected as a bounce has its result
// registered as it is taken from the head of the queue; a calibrating limit event and a
// column tick both pass through the 32-step shared divider (one quotient bit per cycle),
// followed by a position step and, for a tick, a read of the column store.
// Register min_sweep_us sits at byte address 0 and should be written only while idle.
module pov_column_scanner_top #(
    parameter int COLUMNS     = pcs_pkg::COLUMNS_DEF,
    parameter int QUEUE_DEPTH = pcs_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [1:0]                    i_req_type,
    input  wire logic [pcs_pkg::NOW_W-1:0]     i_now_us,
    input  wire logic [pcs_pkg::COL_W-1:0]     i_write_column,
    input  wire logic [pcs_pkg::BITS_W-1:0]    i_column_bits,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [1:0]                         o_result_kind,
    output logic [pcs_pkg::COL_W-1:0]          o_column_index,
    output logic [pcs_pkg::BITS_W-1:0]         o_row_bits,
    output logic                               o_direction,
    output logic [pcs_pkg::PERIOD_W-1:0]       o_column_period_us,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [pcs_pkg::CFG_AW-1:0]    paddr,
    input  wire logic [pcs_pkg::CFG_W-1:0]     pwdata,
    output logic [pcs_pkg::CFG_W-1:0]          prdata,
    output logic                               pready
);

    logic [pcs_pkg::CFG_W-1:0] r_min_sweep;
    logic                      reg_hit;
    logic                      push;
    pcs_pkg::t_item            push_item;
    logic                      q_full;
    logic                      pop;
    pcs_pkg::t_item            head_item;
    logic                      q_empty;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[pcs_pkg::CFG_AW-1:2] == pcs_pkg::REG_MIN_SWEEP);
    assign prdata  = reg_hit ? r_min_sweep : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_sweep <= pcs_pkg::MIN_SWEEP_RESET;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_min_sweep <= pwdata;
        end
    end

    pcs_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in_valid),
        .o_ready        (o_in_ready),
        .i_req_type     (i_req_type),
        .i_now_us       (i_now_us),
        .i_write_column (i_write_column),
        .i_column_bits  (i_column_bits),
        .o_push         (push),
        .o_item         (push_item),
        .i_full         (q_full)
    );

    pcs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_empty (q_empty)
    );

    pcs_back #(
        .COLUMNS (COLUMNS)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_min_sweep_us     (r_min_sweep),
        .i_item             (head_item),
        .i_empty            (q_empty),
        .o_pop              (pop),
        .o_valid            (o_out_valid),
        .i_ready            (i_out_ready),
        .o_result_kind      (o_result_kind),
        .o_column_index     (o_column_index),
        .o_row_bits         (o_row_bits),
        .o_direction        (o_direction),
        .o_column_period_us (o_column_period_us)
    );

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench of the column scanner: directed table, then random phases.
`timescale 1ns / 1ps

module tb_top;
    import pcs_pkg::*;

    localparam int          COLUMNS         = COLUMNS_DEF;
    localparam logic [31:0] LAST_COL        = 32'(COLUMNS - 1);
    localparam logic [CFG_AW-1:0] MIN_SWEEP_ADDR = {REG_MIN_SWEEP, 2'b00};
    localparam int          PLAN_ROWS       = 26;
    localparam int          ITEMS_PER_PHASE = 160;
    localparam int          SWEEP_SPAN      = 2000000;
    localparam int          STALL_LIMIT     = 2000;
    localparam int          DRAIN_CYCLES    = 50;
    localparam logic [63:0] ONES            = '1;
    localparam logic [63:0] COL0_BITS       = 64'h0123_4567_89AB_CDEF;
    localparam logic [63:0] COL0_ROWS       = 64'hEFCD_AB89_6745_2301;

    typedef struct packed {
        t_kind                kind;
        logic [COL_W-1:0]     col;
        logic [BITS_W-1:0]    rows;
        logic                 dir;
        logic [PERIOD_W-1:0]  period;
    } t_result;

    typedef struct packed {
        logic                 is_cfg;
        logic                 typed;
        t_req                 op;
        logic [NOW_W-1:0]     now;
        logic [COL_W-1:0]     col;
        logic [BITS_W-1:0]    bits;
        t_result              want;
    } t_row;

    logic                   i_clk;
    logic                   i_rst_n        = 1'b0;
    logic                   i_in_valid     = 1'b0;
    logic                   o_in_ready;
    logic [1:0]             i_req_type     = '0;
    logic [NOW_W-1:0]       i_now_us       = '0;
    logic [COL_W-1:0]       i_write_column = '0;
    logic [BITS_W-1:0]      i_column_bits  = '0;
    logic                   o_out_valid;
    logic                   i_out_ready    = 1'b0;
    logic [1:0]             o_result_kind;
    logic [COL_W-1:0]       o_column_index;
    logic [BITS_W-1:0]      o_row_bits;
    logic                   o_direction;
    logic [PERIOD_W-1:0]    o_column_period_us;
    logic                   psel           = 1'b0;
    logic                   penable        = 1'b0;
    logic                   pwrite         = 1'b0;
    logic [CFG_AW-1:0]      paddr          = '0;
    logic [CFG_W-1:0]       pwdata         = '0;
    logic [CFG_W-1:0]       prdata;
    logic                   pready;

    // Scanner state as the predictor sees it.
    logic [BITS_W-1:0]      column_mem [STORE_DEPTH];
    logic                   col_written [STORE_DEPTH];
    logic [COL_W-1:0]       written_cols [$];
    logic [NOW_W-1:0]       sync_us    = '0;
    logic [PERIOD_W-1:0]    col_period = PERIOD_RESET;
    logic                   head_dir   = 1'b0;
    logic [CFG_W-1:0]       min_sweep  = MIN_SWEEP_RESET;

    t_result                results_due [$];
    t_row                   plan [PLAN_ROWS];
    int unsigned            send_idle_pct = 26;
    int unsigned            recv_idle_pct = 60;
    int                     error_count   = 0;
    int                     stalled_cycles = 0;

    pov_column_scanner_top u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_req_type         (i_req_type),
        .i_now_us           (i_now_us),
        .i_write_column     (i_write_column),
        .i_column_bits      (i_column_bits),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_result_kind      (o_result_kind),
        .o_column_index     (o_column_index),
        .o_row_bits         (o_row_bits),
        .o_direction        (o_direction),
        .o_column_period_us (o_column_period_us),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        foreach (col_written[c]) col_written[c] = 1'b0;
    end

    // Column that a tick at the given time draws under the current sweep state.
    function automatic logic [COL_W-1:0] drawn_column(input logic [NOW_W-1:0] now);
        logic [31:0] pos;
        if (col_period == 0) pos = LAST_COL;
        else pos = (now - sync_us) / 32'(col_period);
        if (pos > LAST_COL) pos = LAST_COL;
        if (!head_dir) pos = LAST_COL - pos;
        return pos[COL_W-1:0];
    endfunction

    function automatic t_result scan_request(input t_req op, input logic [NOW_W-1:0] now,
                                             input logic [COL_W-1:0] col,
                                             input logic [BITS_W-1:0] bits);
        t_result            res;
        logic [NOW_W-1:0]   sweep;
        logic [31:0]        quot;
        logic [BITS_W-1:0]  stored;
        res = '0;
        case (op)
            REQ_TICK: begin
                res.kind = KIND_DRAWN;
                res.col  = drawn_column(now);
                stored   = column_mem[res.col];
                for (int k = 0; k < 8; k++) res.rows[8*k +: 8] = stored[8*(7-k) +: 8];
            end
            REQ_LEFT, REQ_RIGHT: begin
                sweep    = now - sync_us;
                res.kind = KIND_BOUNCE;
                if (sweep >= min_sweep) begin
                    quot       = sweep / 32'(COLUMNS);
                    col_period = (quot > 32'(PERIOD_MAX)) ? PERIOD_MAX : quot[PERIOD_W-1:0];
                    sync_us    = now;
                    res.kind   = KIND_CAL;
                end
                head_dir = (op == REQ_LEFT);
            end
            default: begin
                column_mem[col] = bits;
                if (!col_written[col]) begin
                    col_written[col] = 1'b1;
                    written_cols.push_back(col);
                end
                res.kind = KIND_STORED;
                res.col  = col;
            end
        endcase
        res.dir    = head_dir;
        res.period = col_period;
        return res;
    endfunction

    function automatic t_row step_row(input t_req op, input logic [NOW_W-1:0] now,
                                      input logic [COL_W-1:0] col,
                                      input logic [BITS_W-1:0] bits);
        t_row r;
        r      = '0;
        r.op   = op;
        r.now  = now;
        r.col  = col;
        r.bits = bits;
        return r;
    endfunction

    function automatic t_row checked_row(input t_req op, input logic [NOW_W-1:0] now,
                                         input logic [COL_W-1:0] col,
                                         input logic [BITS_W-1:0] bits, input t_kind kind,
                                         input logic [COL_W-1:0] x_col,
                                         input logic [BITS_W-1:0] x_rows, input logic x_dir,
                                         input logic [PERIOD_W-1:0] x_period);
        t_row r;
        r = step_row(op, now, col, bits);
        r.typed       = 1'b1;
        r.want.kind   = kind;
        r.want.col    = x_col;
        r.want.rows   = x_rows;
        r.want.dir    = x_dir;
        r.want.period = x_period;
        return r;
    endfunction

    function automatic t_row cfg_row(input logic [CFG_W-1:0] value);
        t_row r;
        r        = '0;
        r.is_cfg = 1'b1;
        r.now    = value;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH at %0t: %s got %h expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    // Valid stays high after a word is taken; the next word or an idle cycle decides.
    task automatic send_word(input t_req op, input logic [NOW_W-1:0] now,
                             input logic [COL_W-1:0] col, input logic [BITS_W-1:0] bits,
                             input logic typed, input t_result typed_res);
        t_result res;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_req_type     <= op;
        i_now_us       <= now;
        i_write_column <= col;
        i_column_bits  <= bits;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        res = scan_request(op, now, col, bits);
        if (typed) res = typed_res;
        results_due.push_back(res);
    endtask

    // Register writes go in only while nothing is in flight.
    task automatic write_min_sweep(input logic [CFG_W-1:0] value);
        i_in_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MIN_SWEEP_ADDR;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        min_sweep  = value;
        // A pause with psel low keeps back-to-back writes apart.
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) stalled_cycles <= 0;
        else stalled_cycles <= stalled_cycles + 1;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (results_due.size() == 0) begin
                report_mismatch("result word with nothing expected, column_index",
                                64'(o_column_index), 64'(0));
            end else begin
                want = results_due.pop_front();
                if (o_result_kind !== want.kind)
                    report_mismatch("result_kind", 64'(o_result_kind), 64'(want.kind));
                if (o_column_index !== want.col)
                    report_mismatch("column_index", 64'(o_column_index), 64'(want.col));
                if (o_row_bits !== want.rows)
                    report_mismatch("row_bits", o_row_bits, want.rows);
                if (o_direction !== want.dir)
                    report_mismatch("direction", 64'(o_direction), 64'(want.dir));
                if (o_column_period_us !== want.period)
                    report_mismatch("column_period_us", 64'(o_column_period_us),
                                    64'(want.period));
            end
        end
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        while (stalled_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("Verification failed");
        $finish;
    end

    initial begin
        t_req               op;
        logic [NOW_W-1:0]   now;
        logic [COL_W-1:0]   col;
        logic [BITS_W-1:0]  bits;
        logic [COL_W-1:0]   tgt;
        logic [COL_W-1:0]   pos;
        logic [63:0]        base;
        logic [63:0]        sweep64;
        logic [31:0]        span;
        int unsigned        pick;

        plan = '{
            checked_row(REQ_WRITE, 32'd0, 10'd0, COL0_BITS, KIND_STORED, 10'd0, '0, 1'b0,
                        PERIOD_RESET),
            checked_row(REQ_WRITE, 32'hFFFF_FFFF, 10'd1023, ONES, KIND_STORED, 10'd1023, '0,
                        1'b0, PERIOD_RESET),
            // Right-to-left at time zero mirrors position zero onto the last column.
            checked_row(REQ_TICK, 32'd0, 10'd0, '0, KIND_DRAWN, 10'd1023, ONES, 1'b0,
                        PERIOD_RESET),
            // A late tick clamps to the last position, which mirrors to column zero.
            checked_row(REQ_TICK, 32'hFFFF_FFFF, 10'd0, '0, KIND_DRAWN, 10'd0, COL0_ROWS, 1'b0,
                        PERIOD_RESET),
            checked_row(REQ_LEFT, 32'd9999, 10'd0, '0, KIND_BOUNCE, 10'd0, '0, 1'b1,
                        PERIOD_RESET),
            checked_row(REQ_RIGHT, 32'd10000, 10'd0, '0, KIND_CAL, 10'd0, '0, 1'b0, 22'd9),
            // The timestamp wraps, so this is the longest sweep there is.
            checked_row(REQ_LEFT, 32'd9999, 10'd0, '0, KIND_CAL, 10'd0, '0, 1'b1, PERIOD_MAX),
            checked_row(REQ_TICK, 32'd4290781968, 10'd0, '0, KIND_DRAWN, 10'd1023, ONES, 1'b1,
                        PERIOD_MAX),
            step_row(REQ_WRITE, 32'd77, 10'd512, 64'hA5A5_5A5A_0F0F_F0F0),
            step_row(REQ_TICK, 32'd2147493135, 10'd0, '0),
            cfg_row(32'd0),
            // A sweep shorter than the column count leaves a zero period.
            checked_row(REQ_RIGHT, 32'd10499, 10'd0, '0, KIND_CAL, 10'd0, '0, 1'b0, 22'd0),
            checked_row(REQ_TICK, 32'd12345, 10'd0, '0, KIND_DRAWN, 10'd0, COL0_ROWS, 1'b0,
                        22'd0),
            checked_row(REQ_LEFT, 32'd10499, 10'd0, '0, KIND_CAL, 10'd0, '0, 1'b1, 22'd0),
            checked_row(REQ_TICK, 32'd0, 10'd0, '0, KIND_DRAWN, 10'd1023, ONES, 1'b1, 22'd0),
            cfg_row(32'hFFFF_FFFF),
            checked_row(REQ_RIGHT, 32'd10497, 10'd0, '0, KIND_BOUNCE, 10'd0, '0, 1'b0, 22'd0),
            checked_row(REQ_LEFT, 32'd10498, 10'd0, '0, KIND_CAL, 10'd0, '0, 1'b1, PERIOD_MAX),
            cfg_row(32'd1024),
            checked_row(REQ_RIGHT, 32'd11522, 10'd0, '0, KIND_CAL, 10'd0, '0, 1'b0, 22'd1),
            step_row(REQ_WRITE, 32'd7, 10'd700, 64'h5555_AAAA_3333_CCCC),
            step_row(REQ_TICK, 32'd11845, 10'd0, '0),
            step_row(REQ_WRITE, 32'd8, 10'h155, 64'hFEDC_BA98_7654_3210),
            step_row(REQ_WRITE, 32'd9, 10'h2AA, 64'h0123_4567_89AB_CDEF ^ ONES),
            checked_row(REQ_TICK, 32'd16522, 10'd0, '0, KIND_DRAWN, 10'd0, COL0_ROWS, 1'b0,
                        22'd1),
            cfg_row(MIN_SWEEP_RESET)
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[r]) begin
            if (plan[r].is_cfg) write_min_sweep(plan[r].now);
            else send_word(plan[r].op, plan[r].now, plan[r].col, plan[r].bits, plan[r].typed,
                           plan[r].want);
        end

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 26;
                    recv_idle_pct = 60;
                    write_min_sweep($urandom_range(100000, 1024));
                end
                1: begin
                    send_idle_pct = 60;
                    recv_idle_pct = 26;
                    write_min_sweep($urandom);
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    write_min_sweep($urandom_range(1023));
                end
            endcase
            repeat (ITEMS_PER_PHASE) begin
                pick = $urandom_range(99);
                col  = $urandom_range(1023);
                bits = {$urandom, $urandom};
                now  = $urandom;
                if (pick < 30) op = REQ_WRITE;
                else if (pick < 70) op = REQ_TICK;
                else if (pick < 85) op = REQ_LEFT;
                else op = REQ_RIGHT;
                if (op == REQ_TICK) begin
                    // Mostly aim at a column that holds data; a random time only stands when it lands on one
                    // or the period is zero. With a zero period the end columns are drawn.
                    if (col_period != 0 &&
                        ($urandom_range(3) != 0 || !col_written[drawn_column(now)])) begin
                        tgt  = written_cols[$urandom_range(written_cols.size() - 1)];
                        pos  = head_dir ? tgt : LAST_COL[COL_W-1:0] - tgt;
                        base = 64'(pos) * 64'(col_period);
                        span = (pos == LAST_COL[COL_W-1:0]) ? 32'hFFFF_FFFF - base[31:0]
                                                            : 32'(col_period) - 32'd1;
                        now  = sync_us + base[31:0] + $urandom_range(span);
                    end
                end else if (op != REQ_WRITE && $urandom_range(4) != 0) begin
                    if (min_sweep != 0 && $urandom_range(3) == 0) begin
                        now = sync_us + $urandom_range(min_sweep - 1);
                    end else begin
                        sweep64 = 64'(min_sweep) + (($urandom_range(7) == 0) ? 64'($urandom)
                                  : 64'($urandom_range(SWEEP_SPAN)));
                        if (sweep64 > 64'hFFFF_FFFF) sweep64 = 64'hFFFF_FFFF;
                        now = sync_us + sweep64[31:0];
                    end
                end
                send_word(op, now, col, bits, 1'b0, '0);
            end
        end

        i_in_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
